FILE: rtl/qmpc_pkg.sv
// Package for the quadrature meter pulse counter: event codes, direction and
// error pattern codes, register indexes and the state and result records.
// No dependencies; qmpc_update and the top level use it by scoped names.
package qmpc_pkg;

  // Default reload value of the encoder counter (top of its 16-bit range).
  localparam int unsigned ReloadValueDefault = 65535;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [2:0] {
    ACT_COMPARE = 3'd0,
    ACT_RELOAD  = 3'd1,
    ACT_UP      = 3'd2,
    ACT_DOWN    = 3'd3,
    ACT_POLL    = 3'd4,
    ACT_START   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_FWD     = 2'd1,
    DIR_BWD     = 2'd2
  } dir_e;

  // Back-and-forth detector: idle, backward seen waiting for forward,
  // forward seen waiting for the closing backward step.
  typedef enum logic [1:0] {
    PAT_NONE            = 2'd0,
    PAT_BWD_EXP_FWD     = 2'd1,
    PAT_FWD_EXP_BWD_END = 2'd2
  } pat_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_INVERT_MODE   = 3'd0,
    CFG_ERROR_CHECK   = 3'd1,
    CFG_USE_COMP      = 3'd2,
    CFG_CONFIRM_COUNT = 3'd3,
    CFG_OFFSET_VALUE  = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic        invert_mode;
    logic        error_check_enable;
    logic        use_compensation;
    logic [7:0]  confirm_count;
    logic [31:0] offset_value;
  } cfg_t;

  // The wrap multiplier is held already scaled by the reload period, so the
  // extended count needs an add and no multiplier.
  typedef struct packed {
    logic [31:0] wrap_product;
    dir_e        dir;
    logic [15:0] start_error;
    pat_e        pat;
    logic        just_started;
    logic [15:0] pattern_counter;
    logic        comp_started;
    logic [31:0] previous_pulse;
  } state_t;

  typedef struct packed {
    logic [31:0] meter_value;
    dir_e        direction;
    logic [15:0] pattern_count;
    logic        compensating;
  } result_t;

endpackage

FILE: rtl/qmpc_update.sv
// Next-state and result logic of the quadrature meter pulse counter for one
// event. Purely combinational; depends on qmpc_pkg.
module qmpc_update #(
  parameter int unsigned RELOAD_VALUE = qmpc_pkg::ReloadValueDefault
) (
  input  qmpc_pkg::cfg_t    cfg_i,
  input  qmpc_pkg::state_t  state_i,
  input  logic [2:0]        action_i,
  input  logic [15:0]       raw_count_i,
  input  logic              up_flag_i,
  input  logic              down_flag_i,
  output qmpc_pkg::state_t  state_o,
  output qmpc_pkg::result_t result_o
);

  localparam logic [16:0] Period17 = 17'(RELOAD_VALUE + 1);
  localparam logic [31:0] Period32 = 32'(RELOAD_VALUE + 1);

  qmpc_pkg::action_e eff_action;
  logic [16:0]       mirror;
  logic [15:0]       pulse;
  logic [31:0]       cur_old;
  logic [31:0]       cur_new;
  logic [31:0]       comp_add;

  // With inverted wiring the event roles swap pairwise.
  always_comb begin
    case (action_i)
      qmpc_pkg::ACT_COMPARE: eff_action = cfg_i.invert_mode ? qmpc_pkg::ACT_RELOAD
                                                            : qmpc_pkg::ACT_COMPARE;
      qmpc_pkg::ACT_RELOAD:  eff_action = cfg_i.invert_mode ? qmpc_pkg::ACT_COMPARE
                                                            : qmpc_pkg::ACT_RELOAD;
      qmpc_pkg::ACT_UP:      eff_action = cfg_i.invert_mode ? qmpc_pkg::ACT_DOWN
                                                            : qmpc_pkg::ACT_UP;
      qmpc_pkg::ACT_DOWN:    eff_action = cfg_i.invert_mode ? qmpc_pkg::ACT_UP
                                                            : qmpc_pkg::ACT_DOWN;
      qmpc_pkg::ACT_START:   eff_action = qmpc_pkg::ACT_START;
      default:               eff_action = qmpc_pkg::ACT_POLL;
    endcase
  end

  assign mirror  = Period17 - {1'b0, raw_count_i};
  assign pulse   = cfg_i.invert_mode ? mirror[15:0] : raw_count_i;
  assign cur_old = {16'b0, pulse} + state_i.wrap_product;

  always_comb begin
    qmpc_pkg::dir_e reload_dir;
    qmpc_pkg::pat_e pat_w;
    logic           js_w;
    logic [15:0]    pc_w;
    logic [16:0]    bump;

    state_o    = state_i;
    reload_dir = state_i.dir;
    pat_w      = state_i.pat;
    js_w       = state_i.just_started;
    pc_w       = state_i.pattern_counter;
    bump       = '0;

    case (eff_action)
      qmpc_pkg::ACT_COMPARE: begin
        if (state_i.dir == qmpc_pkg::DIR_UNKNOWN) begin
          state_o.dir = qmpc_pkg::DIR_FWD;
        end
      end
      qmpc_pkg::ACT_RELOAD: begin
        if (reload_dir == qmpc_pkg::DIR_UNKNOWN) begin
          reload_dir = qmpc_pkg::DIR_BWD;
        end
        // The up flag wins when both are pending.
        if (up_flag_i) begin
          reload_dir = cfg_i.invert_mode ? qmpc_pkg::DIR_BWD : qmpc_pkg::DIR_FWD;
        end else if (down_flag_i) begin
          reload_dir = cfg_i.invert_mode ? qmpc_pkg::DIR_FWD : qmpc_pkg::DIR_BWD;
        end
        state_o.dir = reload_dir;
        if (reload_dir == qmpc_pkg::DIR_FWD) begin
          state_o.wrap_product = state_i.wrap_product + Period32;
        end else begin
          state_o.wrap_product = state_i.wrap_product - Period32;
        end
      end
      qmpc_pkg::ACT_UP: begin
        state_o.dir = qmpc_pkg::DIR_FWD;
        if (cfg_i.error_check_enable && state_i.pat == qmpc_pkg::PAT_BWD_EXP_FWD) begin
          state_o.pat = qmpc_pkg::PAT_FWD_EXP_BWD_END;
        end
      end
      qmpc_pkg::ACT_DOWN: begin
        state_o.dir = qmpc_pkg::DIR_BWD;
        if (cfg_i.error_check_enable) begin
          // Any movement since the last backward step breaks the pattern.
          if (cur_old != state_i.previous_pulse) begin
            pat_w = qmpc_pkg::PAT_NONE;
            js_w  = 1'b0;
            if (!state_i.comp_started) begin
              pc_w = '0;
            end
          end
          if (pat_w == qmpc_pkg::PAT_NONE) begin
            js_w  = 1'b1;
            pat_w = qmpc_pkg::PAT_BWD_EXP_FWD;
          end else if (pat_w == qmpc_pkg::PAT_FWD_EXP_BWD_END) begin
            // The first confirmed pattern also counts the one that opened it.
            bump = {1'b0, pc_w} + (js_w ? 17'd2 : 17'd1);
            pc_w = bump[16] ? 16'hFFFF : bump[15:0];
            js_w = 1'b0;
            if (!state_i.comp_started && ({8'b0, cfg_i.confirm_count} <= pc_w)) begin
              state_o.comp_started = 1'b1;
            end
            pat_w = qmpc_pkg::PAT_BWD_EXP_FWD;
          end
          state_o.pat             = pat_w;
          state_o.just_started    = js_w;
          state_o.pattern_counter = pc_w;
          state_o.previous_pulse  = cur_old;
        end
      end
      qmpc_pkg::ACT_START: begin
        state_o.start_error = raw_count_i;
      end
      default: begin
      end
    endcase
  end

  assign cur_new  = {16'b0, pulse} + state_o.wrap_product;
  assign comp_add = (cfg_i.use_compensation && cfg_i.error_check_enable &&
                     state_o.comp_started) ? {14'b0, state_o.pattern_counter, 2'b00}
                                           : 32'b0;

  always_comb begin
    result_o.meter_value   = cur_new - {16'b0, state_o.start_error} + cfg_i.offset_value
                             + comp_add;
    result_o.direction     = state_o.dir;
    if (state_o.pat != qmpc_pkg::PAT_NONE && cur_new == state_o.previous_pulse) begin
      result_o.direction   = qmpc_pkg::DIR_FWD;
    end
    result_o.pattern_count = state_o.pattern_counter;
    result_o.compensating  = state_o.comp_started;
  end

endmodule

FILE: rtl/quadrature_meter_pulse_counter.sv
// Top level of the quadrature meter pulse counter: handshakes, input and
// result registers, configuration registers and the event state.
// Depends on qmpc_pkg and qmpc_update.

// The block extends a 16-bit encoder counter to a 32-bit meter reading. Each
// input transaction carries one counter event with its raw count and yields
// exactly one result transaction. One transaction is taken in every clock
// cycle when the result side keeps up. An event is captured in an input
// register at the edge that accepts it. Once the output register is free,
// the event state is updated and the result is written to the output
// register. The state update of the event logic sets this rate. The input
// register and the output register each hold a transaction, so one further
// transaction is accepted while a finished result waits to be taken. After
// that the input stalls until the result leaves. The wrap multiplier is kept
// pre-scaled by the reload period, which makes the extended count a plain
// add. Configuration writes are always taken and must only be made while no
// transaction is in flight.
module quadrature_meter_pulse_counter #(
  parameter int unsigned RELOAD_VALUE = qmpc_pkg::ReloadValueDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qmpc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [qmpc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  // Event channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         action_i,
  input  logic [15:0]                        raw_count_i,
  input  logic                               up_flag_i,
  input  logic                               down_flag_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        meter_value_o,
  output logic [1:0]                         direction_o,
  output logic [15:0]                        pattern_count_o,
  output logic                               compensating_o
);

  qmpc_pkg::cfg_t    cfg_q, cfg_d;
  qmpc_pkg::state_t  state_q, state_d;
  qmpc_pkg::result_t result_d;

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  s1_action_q;
  logic [15:0] s1_raw_q;
  logic        s1_up_q;
  logic        s1_down_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q;
  logic [1:0]  out_dir_q;
  logic [15:0] out_pc_q;
  logic        out_comp_q;

  logic advance;
  logic in_fire;
  logic cfg_fire;

  // The output register frees up when it is empty or being taken; the
  // captured event then moves on and the input register can refill.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Configuration register decode. Writes beyond the register list are
  // accepted and ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        qmpc_pkg::CFG_INVERT_MODE:   cfg_d.invert_mode        = cfg_data_i[0];
        qmpc_pkg::CFG_ERROR_CHECK:   cfg_d.error_check_enable = cfg_data_i[0];
        qmpc_pkg::CFG_USE_COMP:      cfg_d.use_compensation   = cfg_data_i[0];
        qmpc_pkg::CFG_CONFIRM_COUNT: cfg_d.confirm_count      = cfg_data_i[7:0];
        qmpc_pkg::CFG_OFFSET_VALUE:  cfg_d.offset_value       = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  qmpc_update #(
    .RELOAD_VALUE(RELOAD_VALUE)
  ) u_update (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .action_i   (s1_action_q),
    .raw_count_i(s1_raw_q),
    .up_flag_i  (s1_up_q),
    .down_flag_i(s1_down_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Control state and the event state, which has defined reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_raw_q    <= raw_count_i;
      s1_up_q     <= up_flag_i;
      s1_down_q   <= down_flag_i;
    end
    if (advance && s1_valid_q) begin
      out_value_q <= result_d.meter_value;
      out_dir_q   <= result_d.direction;
      out_pc_q    <= result_d.pattern_count;
      out_comp_q  <= result_d.compensating;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign meter_value_o   = out_value_q;
  assign direction_o     = out_dir_q;
  assign pattern_count_o = out_pc_q;
  assign compensating_o  = out_comp_q;

endmodule

FILE: rtl/qmpc_checker.sv
// Port-level checks for the quadrature meter pulse counter, bound to the top
// level. Depends only on the top level's ports.
module qmpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] meter_value_o,
  input logic [15:0] pattern_count_o,
  input logic        compensating_o
);

  logic [1:0]  pending_q, pending_d;
  logic        comp_seen_q;
  logic [15:0] last_pc_q;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      comp_seen_q <= 1'b0;
      last_pc_q   <= '0;
    end else begin
      pending_q <= pending_d;
      if (out_fire && compensating_o) begin
        comp_seen_q <= 1'b1;
        last_pc_q   <= pattern_count_o;
      end
    end
  end

  // A result is only shown for an accepted transaction.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result shown without an accepted transaction");

  // The block holds at most two transactions in flight.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more transactions in flight than the block can hold");

  // Compensation never switches off again, and the pattern count it relies on
  // never falls.
  a_comp_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && comp_seen_q |-> compensating_o && (pattern_count_o >= last_pc_q))
    else $error("compensation dropped or pattern count fell");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(meter_value_o))
    else $error("stalled result changed");

endmodule

bind quadrature_meter_pulse_counter qmpc_checker u_qmpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .meter_value_o  (meter_value_o),
  .pattern_count_o(pattern_count_o),
  .compensating_o (compensating_o)
);
